// ----- rtl/mrtu_pkg.sv -----
// ----------------------------------------------------------------------------
// mrtu_pkg: shared types and constants of the Modbus RTU frame receiver
// Phase codes, register indexes, result record and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mrtu_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CRC_W       = 16;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam int unsigned MAX_PAYLOAD_DEFAULT = 252;

    localparam logic [BYTE_W-1:0] OWN_ADDRESS_RST  = 8'd1;
    localparam logic [BYTE_W-1:0] PAYLOAD_SIZE_RST = 8'd4;
    localparam logic [CRC_W-1:0]  CRC_INIT         = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY         = 16'hA001;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OWN_ADDRESS  = 1'b0,
        CFG_PAYLOAD_SIZE = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_FUNC = 3'd1,
        PH_DATA = 3'd2,
        PH_CRCL = 3'd3,
        PH_CRCH = 3'd4
    } phase_t;

    typedef struct packed {
        logic              frame_valid;
        logic [BYTE_W-1:0] function_code;
        logic              payload_strobe;
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] payload_value;
        logic [CRC_W-1:0]  received_crc;
    } result_t;

    // Reflected CRC-16 update over one byte, LSB first.
    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/mrtu_in_if.sv -----
// ----------------------------------------------------------------------------
// mrtu_in_if: byte request channel of the Modbus RTU frame receiver
// Carries one received byte or a restart request per handshake.
// ----------------------------------------------------------------------------
interface mrtu_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [mrtu_pkg::BYTE_W-1:0]   byte_value;

    modport source (output valid, output action, output byte_value, input ready);
    modport sink   (input valid, input action, input byte_value, output ready);
endinterface

// ----- rtl/mrtu_out_if.sv -----
// ----------------------------------------------------------------------------
// mrtu_out_if: result channel of the Modbus RTU frame receiver
// Carries one parse result per accepted request.
// ----------------------------------------------------------------------------
interface mrtu_out_if;
    logic                          valid;
    logic                          ready;
    logic                          frame_valid;
    logic [mrtu_pkg::BYTE_W-1:0]   function_code;
    logic                          payload_strobe;
    logic [mrtu_pkg::BYTE_W-1:0]   payload_index;
    logic [mrtu_pkg::BYTE_W-1:0]   payload_value;
    logic [mrtu_pkg::CRC_W-1:0]    received_crc;

    modport source (
        output valid, output frame_valid, output function_code, output payload_strobe,
        output payload_index, output payload_value, output received_crc, input ready
    );
    modport sink (
        input valid, input frame_valid, input function_code, input payload_strobe,
        input payload_index, input payload_value, input received_crc, output ready
    );
endinterface

// ----- rtl/mrtu_parser.sv -----
// ----------------------------------------------------------------------------
// mrtu_parser: frame phase tracking and CRC accumulation
// Holds the parse state, advances it by one byte per accepted request and
// presents the result of that byte combinationally.
// ----------------------------------------------------------------------------
module mrtu_parser #(
    parameter int unsigned MAX_PAYLOAD = mrtu_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        action,
    input  logic [mrtu_pkg::BYTE_W-1:0] byte_value,
    input  logic [mrtu_pkg::BYTE_W-1:0] own_address,
    input  logic [mrtu_pkg::BYTE_W-1:0] payload_size,
    output mrtu_pkg::result_t           result
);

    localparam logic [mrtu_pkg::BYTE_W-1:0] MAX_SIZE = mrtu_pkg::BYTE_W'(MAX_PAYLOAD);

    mrtu_pkg::phase_t              phase_reg, phase_next;
    logic [mrtu_pkg::CRC_W-1:0]    running_crc_reg, running_crc_next;
    logic [mrtu_pkg::CRC_W-1:0]    crc_check_reg, crc_check_next;
    logic [mrtu_pkg::BYTE_W-1:0]   payload_count_reg, payload_count_next;
    logic [mrtu_pkg::BYTE_W-1:0]   function_reg, function_next;
    logic [mrtu_pkg::BYTE_W-1:0]   crc_low_reg, crc_low_next;
    logic [mrtu_pkg::BYTE_W-1:0]   crc_high_reg, crc_high_next;

    logic [mrtu_pkg::BYTE_W-1:0]   size_eff;
    logic [mrtu_pkg::BYTE_W-1:0]   count_inc;
    logic                          count_below;
    logic [mrtu_pkg::CRC_W-1:0]    crc_base;
    logic [mrtu_pkg::CRC_W-1:0]    crc_upd;
    logic [mrtu_pkg::CRC_W-1:0]    crc_final;

    assign size_eff    = (payload_size > MAX_SIZE) ? MAX_SIZE : payload_size;
    assign count_inc   = payload_count_reg + 8'd1;
    assign count_below = payload_count_reg < size_eff;
    // A new frame restarts the CRC from its seed.
    assign crc_base    = (phase_reg == mrtu_pkg::PH_FUNC || phase_reg == mrtu_pkg::PH_DATA)
                         ? running_crc_reg : mrtu_pkg::CRC_INIT;
    assign crc_upd     = mrtu_pkg::crc_byte(crc_base, byte_value);
    assign crc_final   = crc_check_reg ^ {byte_value, 8'h00};

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (action)
        begin
            phase_next = mrtu_pkg::PH_HUNT;
        end
        else
        begin
            unique case (phase_reg)
                mrtu_pkg::PH_FUNC: phase_next = mrtu_pkg::PH_DATA;
                mrtu_pkg::PH_DATA:
                begin
                    if (!count_below)
                    begin
                        phase_next = mrtu_pkg::PH_HUNT;
                    end
                    else if (count_inc == size_eff)
                    begin
                        phase_next = mrtu_pkg::PH_CRCL;
                    end
                end
                mrtu_pkg::PH_CRCL: phase_next = mrtu_pkg::PH_CRCH;
                mrtu_pkg::PH_CRCH: phase_next = mrtu_pkg::PH_HUNT;
                default:
                begin
                    phase_next = (byte_value == own_address)
                                 ? mrtu_pkg::PH_FUNC : mrtu_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // Datapath and result
    always_comb
    begin
        running_crc_next   = running_crc_reg;
        crc_check_next     = crc_check_reg;
        payload_count_next = payload_count_reg;
        function_next      = function_reg;
        crc_low_next       = crc_low_reg;
        crc_high_next      = crc_high_reg;
        result             = '0;
        if (action)
        begin
            running_crc_next   = mrtu_pkg::CRC_INIT;
            payload_count_next = '0;
            function_next      = '0;
            crc_low_next       = '0;
            crc_high_next      = '0;
        end
        else
        begin
            unique case (phase_reg)
                mrtu_pkg::PH_FUNC:
                begin
                    function_next      = byte_value;
                    payload_count_next = '0;
                    running_crc_next   = crc_upd;
                end
                mrtu_pkg::PH_DATA:
                begin
                    if (count_below)
                    begin
                        result.payload_strobe = 1'b1;
                        result.payload_index  = payload_count_reg;
                        result.payload_value  = byte_value;
                        payload_count_next    = count_inc;
                        running_crc_next      = crc_upd;
                    end
                end
                mrtu_pkg::PH_CRCL:
                begin
                    crc_check_next = running_crc_reg ^ {8'h00, byte_value};
                    crc_low_next   = byte_value;
                end
                mrtu_pkg::PH_CRCH:
                begin
                    crc_check_next     = crc_final;
                    crc_high_next      = byte_value;
                    result.frame_valid = (crc_final == '0);
                end
                default:
                begin
                    if (byte_value == own_address)
                    begin
                        running_crc_next = crc_upd;
                    end
                end
            endcase
        end
        result.function_code = function_next;
        result.received_crc  = {crc_high_next, crc_low_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= mrtu_pkg::PH_HUNT;
            running_crc_reg   <= mrtu_pkg::CRC_INIT;
            crc_check_reg     <= '0;
            payload_count_reg <= '0;
            function_reg      <= '0;
            crc_low_reg       <= '0;
            crc_high_reg      <= '0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            running_crc_reg   <= running_crc_next;
            crc_check_reg     <= crc_check_next;
            payload_count_reg <= payload_count_next;
            function_reg      <= function_next;
            crc_low_reg       <= crc_low_next;
            crc_high_reg      <= crc_high_next;
        end
    end

endmodule

// ----- rtl/modbus_rtu_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver: byte-wise Modbus RTU frame parser with CRC check
// Usage notes for the block follow.
// ----------------------------------------------------------------------------
// Requests arrive on req: action 0 carries a received byte, action 1 restarts
// the parser to address hunting. Every request gives exactly one result on
// rsp: frame_valid pulses on the CRC high byte of a frame whose CRC matches,
// data bytes are streamed with their index, function_code and received_crc
// show the registers after the byte.
// Registers own_address (index 0) and payload_size (index 1) are written
// through cfg_we / cfg_index / cfg_data; change them only while idle.
// The result is registered and valid in the cycle after the request is taken.
// Throughput: one request per cycle while rsp is not stalled; the CRC byte update
// (eight shift steps) sits in the single stage between request port and result register.
// rsp stalls hold the result register; req.ready stays high as long as the
// result register is empty or being drained in the same cycle.
// Reset: parser returns to address hunting, CRC to its seed, registers to
// own_address 1 and payload_size 4; the result register is empty.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver #(
    parameter int unsigned MAX_PAYLOAD = mrtu_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mrtu_in_if.sink                          req,
    mrtu_out_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [mrtu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mrtu_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [mrtu_pkg::BYTE_W-1:0] own_address_reg;
    logic [mrtu_pkg::BYTE_W-1:0] payload_size_reg;
    logic                        out_valid_reg;
    mrtu_pkg::result_t           result_reg;
    mrtu_pkg::result_t           result_next;
    logic                        accept;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg  <= mrtu_pkg::OWN_ADDRESS_RST;
            payload_size_reg <= mrtu_pkg::PAYLOAD_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (mrtu_pkg::cfg_index_t'(cfg_index))
                mrtu_pkg::CFG_OWN_ADDRESS:  own_address_reg  <= cfg_data;
                mrtu_pkg::CFG_PAYLOAD_SIZE: payload_size_reg <= cfg_data;
                default:                    own_address_reg  <= own_address_reg;
            endcase
        end
    end

    mrtu_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (accept),
        .action       (req.action),
        .byte_value   (req.byte_value),
        .own_address  (own_address_reg),
        .payload_size (payload_size_reg),
        .result       (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result only on a new request; hold it while stalled.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.frame_valid    = result_reg.frame_valid;
    assign rsp.function_code  = result_reg.function_code;
    assign rsp.payload_strobe = result_reg.payload_strobe;
    assign rsp.payload_index  = result_reg.payload_index;
    assign rsp.payload_value  = result_reg.payload_value;
    assign rsp.received_crc   = result_reg.received_crc;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(out_valid_reg && !rsp.ready))
        else $error("request taken while result register is stalled");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.action |=> rsp.valid && !rsp.frame_valid && !rsp.payload_strobe
            && rsp.function_code == '0 && rsp.received_crc == '0)
        else $error("restart result not cleared");

    a_valid_not_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.frame_valid |-> !rsp.payload_strobe)
        else $error("frame completion on a payload byte");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.payload_strobe
            |-> rsp.payload_index < mrtu_pkg::BYTE_W'(MAX_PAYLOAD))
        else $error("payload index beyond maximum payload");
`endif

endmodule

// ----- bench/modbus_rtu_frame_receiver_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver_tb: self-checking bench of the Modbus RTU receiver
// Drives byte and restart requests with random bursts and gaps, stalls the
// result channel on a shifting pattern, predicts every result in the bench
// and compares each field of every result in order.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver_tb;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 300;
    localparam int unsigned PHASE_ITEMS  = 50;
    localparam int unsigned PAYLOAD_CAP  = mrtu_pkg::MAX_PAYLOAD_DEFAULT;

    typedef enum int unsigned {
        RSP_FREE,
        RSP_RANDOM,
        RSP_PATTERN,
        RSP_HEAVY
    } stall_mode_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [mrtu_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mrtu_pkg::CFG_DATA_W-1:0]  cfg_data;

    mrtu_in_if  req_if ();
    mrtu_out_if rsp_if ();

    modbus_rtu_frame_receiver #(
        .MAX_PAYLOAD (PAYLOAD_CAP)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Parser state as the bench expects it after every accepted request
    mrtu_pkg::phase_t rx_phase   = mrtu_pkg::PH_HUNT;
    logic [15:0]    rx_crc     = mrtu_pkg::CRC_INIT;
    logic [15:0]    rx_check   = '0;
    logic [7:0]     rx_count   = '0;
    logic [7:0]     rx_func    = '0;
    logic [7:0]     rx_crc_lo  = '0;
    logic [7:0]     rx_crc_hi  = '0;
    logic [7:0]     cfg_own    = mrtu_pkg::OWN_ADDRESS_RST;
    logic [7:0]     cfg_size   = mrtu_pkg::PAYLOAD_SIZE_RST;

    mrtu_pkg::result_t pending_results[$];

    int unsigned    cycle_count    = 0;
    int unsigned    error_count    = 0;
    int unsigned    requests_sent  = 0;
    int unsigned    random_items   = 0;
    int unsigned    results_seen   = 0;
    int unsigned    frames_passed  = 0;
    int unsigned    payload_bytes  = 0;
    int unsigned    settings_used  = 1;
    int unsigned    burst_left     = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL modbus_rtu_frame_receiver");
            $finish;
        end
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] seed, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = seed;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
            begin
                c = c ^ mrtu_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    // Advance the expected parser state by one request and queue its result
    task automatic predict_parse(input logic act, input logic [7:0] b);
        mrtu_pkg::result_t r;
        logic [7:0]  lim;
        r   = '0;
        lim = (cfg_size > PAYLOAD_CAP) ? PAYLOAD_CAP[7:0] : cfg_size;
        if (act)
        begin
            rx_phase  = mrtu_pkg::PH_HUNT;
            rx_crc    = mrtu_pkg::CRC_INIT;
            rx_count  = '0;
            rx_func   = '0;
            rx_crc_lo = '0;
            rx_crc_hi = '0;
        end
        else
        begin
            case (rx_phase)
                mrtu_pkg::PH_FUNC:
                begin
                    rx_func  = b;
                    rx_count = '0;
                    rx_crc   = crc16_step(rx_crc, b);
                    rx_phase = mrtu_pkg::PH_DATA;
                end
                mrtu_pkg::PH_DATA:
                begin
                    if (rx_count < lim)
                    begin
                        r.payload_strobe = 1'b1;
                        r.payload_index  = rx_count;
                        r.payload_value  = b;
                        rx_count = rx_count + 8'd1;
                        rx_crc   = crc16_step(rx_crc, b);
                        if (rx_count == lim)
                        begin
                            rx_phase = mrtu_pkg::PH_CRCL;
                        end
                    end
                    else
                    begin
                        // zero size: this byte aborts and is not an address
                        rx_phase = mrtu_pkg::PH_HUNT;
                    end
                end
                mrtu_pkg::PH_CRCL:
                begin
                    rx_check  = rx_crc ^ {8'h00, b};
                    rx_crc_lo = b;
                    rx_phase  = mrtu_pkg::PH_CRCH;
                end
                mrtu_pkg::PH_CRCH:
                begin
                    rx_check  = rx_check ^ {b, 8'h00};
                    rx_crc_hi = b;
                    rx_phase  = mrtu_pkg::PH_HUNT;
                    r.frame_valid = (rx_check == 16'h0000);
                end
                default:
                begin
                    rx_phase = mrtu_pkg::PH_HUNT;
                    if (b == cfg_own)
                    begin
                        rx_crc   = crc16_step(mrtu_pkg::CRC_INIT, b);
                        rx_phase = mrtu_pkg::PH_FUNC;
                    end
                end
            endcase
        end
        r.function_code = rx_func;
        r.received_crc  = {rx_crc_hi, rx_crc_lo};
        pending_results.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR %0t ns result %0d: %s", $time, results_seen, msg);
    endtask

    // Call at a rising edge; returns once the request is taken and any gap after it is done
    task automatic send_request(input logic act, input logic [7:0] b);
        int unsigned gap;
        req_if.valid      <= 1'b1;
        req_if.action     <= act;
        req_if.byte_value <= b;
        @(posedge clk);
        while (req_if.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        predict_parse(act, b);
        requests_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
            if (gap != 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Hold off the sender until every result has come back
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(input mrtu_pkg::cfg_index_t idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            mrtu_pkg::CFG_OWN_ADDRESS:  cfg_own  = val;
            mrtu_pkg::CFG_PAYLOAD_SIZE: cfg_size = val;
            default: ;
        endcase
    endtask

    // Restart if not hunting, then address, function, random data and CRC; crc_flip breaks the check
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
                              input int unsigned n_data, input logic [15:0] crc_flip);
        logic [15:0] c;
        logic [7:0]  d;
        if (rx_phase != mrtu_pkg::PH_HUNT)
        begin
            send_request(1'b1, 8'($urandom_range(0, 255)));
        end
        c = crc16_step(mrtu_pkg::CRC_INIT, addr);
        send_request(1'b0, addr);
        c = crc16_step(c, func);
        send_request(1'b0, func);
        for (int unsigned i = 0; i < n_data; i++)
        begin
            d = 8'($urandom_range(0, 255));
            c = crc16_step(c, d);
            send_request(1'b0, d);
        end
        c = c ^ crc_flip;
        send_request(1'b0, c[7:0]);
        send_request(1'b0, c[15:8]);
    endtask

    task automatic test_good_frame();
        send_frame(mrtu_pkg::OWN_ADDRESS_RST, 8'hFF, int'(mrtu_pkg::PAYLOAD_SIZE_RST),
                   16'h0000);
    endtask

    task automatic test_crc_mismatch();
        send_frame(mrtu_pkg::OWN_ADDRESS_RST, 8'h00, int'(mrtu_pkg::PAYLOAD_SIZE_RST),
                   16'h8001);
    endtask

    task automatic test_restart();
        // bytes that are not the address are dropped while hunting
        send_request(1'b0, 8'h00);
        send_request(1'b0, 8'hFF);
        send_request(1'b0, mrtu_pkg::OWN_ADDRESS_RST);
        send_request(1'b0, 8'h10);
        send_request(1'b0, 8'hA5);
        send_request(1'b1, 8'hFF);
        send_request(1'b1, 8'h00);
    endtask

    task automatic test_zero_payload();
        wait_idle();
        write_register(mrtu_pkg::CFG_PAYLOAD_SIZE, 8'd0);
        settings_used++;
        send_request(1'b0, cfg_own);
        send_request(1'b0, 8'h55);
        send_request(1'b0, cfg_own);
        send_request(1'b0, cfg_own);
        send_request(1'b0, 8'h2B);
        send_request(1'b1, 8'h7E);
    endtask

    task automatic test_payload_saturation();
        wait_idle();
        write_register(mrtu_pkg::CFG_OWN_ADDRESS, 8'hFF);
        write_register(mrtu_pkg::CFG_PAYLOAD_SIZE, 8'hFF);
        settings_used++;
        send_frame(8'hFF, 8'h17, PAYLOAD_CAP, 16'h0000);
    endtask

    task automatic test_random_traffic();
        int unsigned phase_no;
        int unsigned start;
        int unsigned pick;
        int unsigned lim;
        logic [7:0]  own;
        phase_no = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            wait_idle();
            case (phase_no)
                0:       begin own = 8'h00; lim = 0; end
                1:       begin own = 8'hFF; lim = 1; end
                default:
                begin
                    own = 8'($urandom_range(0, 255));
                    lim = $urandom_range(0, 10);
                end
            endcase
            write_register(mrtu_pkg::CFG_OWN_ADDRESS, own);
            write_register(mrtu_pkg::CFG_PAYLOAD_SIZE, lim[7:0]);
            settings_used++;
            start = requests_sent;
            while (requests_sent - start < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    send_frame(own, 8'($urandom_range(0, 255)), lim, 16'h0000);
                end
                else if (pick < 70)
                begin
                    send_frame(own, 8'($urandom_range(0, 255)), lim,
                               16'($urandom_range(1, 16'hFFFF)));
                end
                else if (pick < 80)
                begin
                    // drop the frame part way with a restart
                    send_request(1'b0, own);
                    send_request(1'b0, 8'($urandom_range(0, 255)));
                    repeat ($urandom_range(0, lim))
                        send_request(1'b0, 8'($urandom_range(0, 255)));
                    send_request(1'b1, 8'($urandom_range(0, 255)));
                end
                else if (pick < 88)
                begin
                    send_request(1'b0, own ^ 8'($urandom_range(1, 255)));
                    repeat ($urandom_range(1, 4))
                        send_request(1'b0, 8'($urandom_range(0, 255)));
                end
                else if (pick < 96)
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        send_request($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
                    end
                end
                else
                begin
                    wait_idle();
                end
            end
            random_items += requests_sent - start;
            phase_no++;
        end
    endtask

    // Result side: stall on a randomly chosen pattern that changes after each random span
    initial
    begin : rsp_stall
        stall_mode_t mode;
        int unsigned span;
        int unsigned tick;
        rsp_if.ready = 1'b0;
        mode = RSP_FREE;
        span = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                span = $urandom_range(20, 120);
            end
            span--;
            tick++;
            case (mode)
                RSP_FREE:    rsp_if.ready <= 1'b1;
                RSP_RANDOM:  rsp_if.ready <= ($urandom_range(0, 3) != 0);
                RSP_PATTERN: rsp_if.ready <= ((tick % 5) >= 2);
                default:     rsp_if.ready <= ($urandom_range(0, 4) < 2);
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        mrtu_pkg::result_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no request pending");
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_if.frame_valid !== want.frame_valid)
                    report_mismatch($sformatf("frame_valid got %0b expected %0b",
                                              rsp_if.frame_valid, want.frame_valid));
                if (rsp_if.function_code !== want.function_code)
                    report_mismatch($sformatf("function_code got 0x%0h expected 0x%0h",
                                              rsp_if.function_code, want.function_code));
                if (rsp_if.payload_strobe !== want.payload_strobe)
                    report_mismatch($sformatf("payload_strobe got %0b expected %0b",
                                              rsp_if.payload_strobe, want.payload_strobe));
                if (rsp_if.payload_index !== want.payload_index)
                    report_mismatch($sformatf("payload_index got %0d expected %0d",
                                              rsp_if.payload_index, want.payload_index));
                if (rsp_if.payload_value !== want.payload_value)
                    report_mismatch($sformatf("payload_value got 0x%0h expected 0x%0h",
                                              rsp_if.payload_value, want.payload_value));
                if (rsp_if.received_crc !== want.received_crc)
                    report_mismatch($sformatf("received_crc got 0x%0h expected 0x%0h",
                                              rsp_if.received_crc, want.received_crc));
                if (want.frame_valid)
                    frames_passed++;
                if (want.payload_strobe)
                    payload_bytes++;
            end
            results_seen++;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = mrtu_pkg::CFG_OWN_ADDRESS;
        cfg_data          = '0;
        req_if.valid      = 1'b0;
        req_if.action     = 1'b0;
        req_if.byte_value = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_good_frame();
        test_crc_mismatch();
        test_restart();
        test_zero_payload();
        test_payload_saturation();
        test_random_traffic();

        wait_idle();
        repeat (4) @(posedge clk);
        $display("Run covered %0d requests over %0d register settings in %0d cycles",
                 requests_sent, settings_used, cycle_count);
        $display("Checked %0d results: %0d good frames, %0d payload bytes, %0d mismatches",
                 results_seen, frames_passed, payload_bytes, error_count);
        if (error_count == 0)
        begin
            $display("PASS modbus_rtu_frame_receiver");
        end
        else
        begin
            $display("FAIL modbus_rtu_frame_receiver");
        end
        $finish;
    end

endmodule

// ----- modbus_rtu_frame_receiver.f -----
rtl/mrtu_pkg.sv
rtl/mrtu_in_if.sv
rtl/mrtu_out_if.sv
rtl/mrtu_parser.sv
rtl/modbus_rtu_frame_receiver.sv
bench/modbus_rtu_frame_receiver_tb.sv
